>>> design/psmc_pkg.sv
package psmc_pkg;

  localparam int TABLE_ENTRIES = 65536;
  localparam int SLOT_BITS     = $clog2(TABLE_ENTRIES);

  localparam int VALUE_W = 29;
  localparam int KEY_W   = 30;
  localparam int COUNT_W = 32;
  localparam int TOTAL_W = 64;
  localparam int ENTRY_W = KEY_W + COUNT_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // The one sum whose negation does not fit in a key.
  localparam logic [KEY_W-1:0] KEY_NO_NEGATE = {1'b1, {(KEY_W-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT_CLEAR,
    ST_IDLE,
    ST_START,
    ST_PROBE,
    ST_OP_CLEAR,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic sweep;
    logic capture;
    logic start_read;
    logic probe;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic skip;
    logic hit;
    logic last_probe;
    logic sweep_last;
    logic out_free;
  } dp_status_t;

endpackage

>>> design/psmc_ram.sv
module psmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/psmc_datapath.sv
module psmc_datapath (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic [1:0]                              operation,
  input  logic signed [psmc_pkg::VALUE_W-1:0]     first_value,
  input  logic signed [psmc_pkg::VALUE_W-1:0]     second_value,
  input  psmc_pkg::dp_cmd_t                       cmd,
  output psmc_pkg::dp_status_t                    status,
  input  logic                                    result_stall,
  output logic                                    result_valid,
  output logic [psmc_pkg::COUNT_W-1:0]            found_count,
  output logic [psmc_pkg::TOTAL_W-1:0]            match_total,
  output logic                                    table_full
);

  import psmc_pkg::*;

  op_t                  op;
  logic [KEY_W-1:0]     key;
  logic                 skip;
  logic [SLOT_BITS-1:0] slot;
  logic [SLOT_BITS-1:0] probe_cnt;
  logic [SLOT_BITS-1:0] sweep_addr;
  logic [COUNT_W-1:0]   found;
  logic                 full;
  logic [TOTAL_W-1:0]   total;
  logic [TOTAL_W-1:0]   total_next;
  logic [TOTAL_W:0]     total_sum;

  logic [KEY_W-1:0]     sum;
  logic [KEY_W-1:0]     neg_sum;
  logic [KEY_W-1:0]     key_next;
  logic [SLOT_BITS-1:0] slot_inc;

  logic                 rd_en;
  logic [SLOT_BITS-1:0] rd_addr;
  logic [ENTRY_W-1:0]   rd_data;
  logic                 wr_en;
  logic [SLOT_BITS-1:0] wr_addr;
  logic [ENTRY_W-1:0]   wr_data;
  logic [KEY_W-1:0]     rd_key;
  logic [COUNT_W-1:0]   rd_count;
  logic [COUNT_W-1:0]   new_count;
  logic                 hit;
  logic                 last;

  assign sum      = KEY_W'(first_value) + KEY_W'(second_value);
  assign neg_sum  = ~sum + KEY_W'(1);
  assign key_next = (op_t'(operation) == OP_LOOKUP) ? neg_sum : sum;
  assign slot_inc = slot + SLOT_BITS'(1);

  assign rd_key    = rd_data[ENTRY_W-1:COUNT_W];
  assign rd_count  = rd_data[COUNT_W-1:0];
  assign hit       = (rd_count == '0) || (rd_key == key);
  assign last      = &probe_cnt;
  assign new_count = (rd_count == COUNT_MAX) ? rd_count : rd_count + COUNT_W'(1);

  always_comb begin
    rd_en   = cmd.start_read | (cmd.probe & ~hit & ~last);
    rd_addr = cmd.probe ? slot_inc : slot;
    wr_en   = cmd.sweep | (cmd.probe & hit & (op == OP_INSERT));
    wr_addr = cmd.sweep ? sweep_addr : slot;
    wr_data = cmd.sweep ? '0 : {key, new_count};
  end

  psmc_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign total_sum = {1'b0, total} + {{(TOTAL_W-COUNT_W+1){1'b0}}, found};

  always_comb begin
    unique case (op)
      OP_LOOKUP: total_next = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
      OP_CLEAR:  total_next = '0;
      default:   total_next = total;
    endcase
  end

  always_comb begin
    status.op         = op;
    status.skip       = skip;
    status.hit        = hit;
    status.last_probe = last;
    status.sweep_last = &sweep_addr;
    status.out_free   = ~result_valid | ~result_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr   <= '0;
      result_valid <= 1'b0;
      total        <= '0;
    end else begin
      if (cmd.sweep) begin
        sweep_addr <= sweep_addr + SLOT_BITS'(1);
      end
      if (cmd.load) begin
        result_valid <= 1'b1;
        total        <= total_next;
      end else if (~result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op        <= op_t'(operation);
      key       <= key_next;
      skip      <= (op_t'(operation) == OP_LOOKUP) && (sum == KEY_NO_NEGATE);
      slot      <= key_next[SLOT_BITS-1:0];
      probe_cnt <= '0;
      found     <= '0;
      full      <= 1'b0;
    end
    if (cmd.probe) begin
      if (hit) begin
        found <= (op == OP_INSERT) ? new_count : rd_count;
      end else if (last) begin
        full <= (op == OP_INSERT);
      end else begin
        slot      <= slot_inc;
        probe_cnt <= probe_cnt + SLOT_BITS'(1);
      end
    end
    if (cmd.load) begin
      found_count <= found;
      table_full  <= full;
    end
  end

  assign match_total = total;

endmodule

>>> design/psmc_ctrl.sv
module psmc_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 request_valid,
  output logic                 request_stall,
  input  psmc_pkg::dp_status_t status,
  output psmc_pkg::dp_cmd_t    cmd
);

  import psmc_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    request_stall = 1'b1;
    unique case (state)
      ST_INIT_CLEAR: begin
        cmd.sweep = 1'b1;
        if (status.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        request_stall = 1'b0;
        if (request_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_START;
        end
      end
      ST_START: begin
        unique case (status.op)
          OP_INSERT: begin
            cmd.start_read = 1'b1;
            state_next     = ST_PROBE;
          end
          OP_LOOKUP: begin
            if (status.skip) begin
              state_next = ST_RESULT;
            end else begin
              cmd.start_read = 1'b1;
              state_next     = ST_PROBE;
            end
          end
          OP_CLEAR: state_next = ST_OP_CLEAR;
          OP_NONE:  state_next = ST_RESULT;
        endcase
      end
      ST_PROBE: begin
        cmd.probe = 1'b1;
        if (status.hit || status.last_probe) begin
          state_next = ST_RESULT;
        end
      end
      ST_OP_CLEAR: begin
        cmd.sweep = 1'b1;
        if (status.sweep_last) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (status.out_free) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_INIT_CLEAR;
    endcase
  end

endmodule

>>> design/pair_sum_match_counter.sv
// Counting hash table keyed by the 30-bit sum of two values, with linear probing over
// TABLE_ENTRIES slots held in one single-port-read RAM. An insert raises the saturating
// count of its sum, a lookup adds the count of the negated sum to a saturating 64-bit
// total, and a clear empties the table and zeroes the total. Each request gives exactly
// one result. An insert or lookup reads its home slot, then probes the following slots
// one per cycle until a slot matches or is free or the last slot is reached; a lookup
// of the one sum that cannot be negated, and an unused operation, do not read the table.
// A clear walks the RAM one slot per cycle. After reset the same walk runs over all
// TABLE_ENTRIES slots before the first request is taken. A finished result waits in
// the output register while the next request is accepted.
module pair_sum_match_counter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                request_valid,
  output logic                                request_stall,
  input  logic [1:0]                          operation,
  input  logic signed [psmc_pkg::VALUE_W-1:0] first_value,
  input  logic signed [psmc_pkg::VALUE_W-1:0] second_value,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [psmc_pkg::COUNT_W-1:0]        found_count,
  output logic [psmc_pkg::TOTAL_W-1:0]        match_total,
  output logic                                table_full
);

  import psmc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  psmc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .request_valid(request_valid),
    .request_stall(request_stall),
    .status       (status),
    .cmd          (cmd)
  );

  psmc_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .operation   (operation),
    .first_value (first_value),
    .second_value(second_value),
    .cmd         (cmd),
    .status      (status),
    .result_stall(result_stall),
    .result_valid(result_valid),
    .found_count (found_count),
    .match_total (match_total),
    .table_full  (table_full)
  );

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import psmc_pkg::*;

  localparam longint VALUE_MAX = (longint'(1) << (VALUE_W - 1)) - 1;
  localparam longint VALUE_MIN = -(longint'(1) << (VALUE_W - 1));
  localparam longint NEGATE_LIMIT = longint'(1) << (KEY_W - 1);
  localparam longint SPAN = TABLE_ENTRIES;
  localparam int RUN_LIMIT = 5000000;
  localparam int HOLD_CYCLES = 200;
  localparam int TAIL_CYCLES = 40;
  localparam int POOL_SIZE = 16;
  localparam int PRINT_LIMIT = 50;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [TOTAL_W-1:0] total;
    logic               full;
  } outcome_t;

  logic clk = 1'b0;
  logic rst;
  logic request_valid;
  logic request_stall;
  logic [1:0] operation;
  logic signed [VALUE_W-1:0] first_value;
  logic signed [VALUE_W-1:0] second_value;
  logic result_valid;
  logic result_stall;
  logic [COUNT_W-1:0] found_count;
  logic [TOTAL_W-1:0] match_total;
  logic table_full;

  logic [KEY_W-1:0] slot_key [TABLE_ENTRIES];
  logic [COUNT_W-1:0] slot_count [TABLE_ENTRIES];
  logic [TOTAL_W-1:0] running_total;
  outcome_t outcome_q [$];
  outcome_t want;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];
  int mismatch_count;
  int cycle_count;
  bit quiet;
  bit hold_request;

  pair_sum_match_counter DUT (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .operation     (operation),
    .first_value   (first_value),
    .second_value  (second_value),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .found_count   (found_count),
    .match_total   (match_total),
    .table_full    (table_full)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int find_slot(logic [KEY_W-1:0] key);
    int slot;
    slot = int'(key[SLOT_BITS-1:0]);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (slot_count[slot] == '0 || slot_key[slot] == key) return slot;
      slot = (slot + 1) % TABLE_ENTRIES;
    end
    return -1;
  endfunction

  function automatic outcome_t hash_table_update(op_t op, logic signed [VALUE_W-1:0] a,
                                                 logic signed [VALUE_W-1:0] b);
    outcome_t res;
    longint pair_sum;
    longint negated;
    logic [KEY_W-1:0] key;
    logic [COUNT_W-1:0] found;
    int slot;
    res.count = '0;
    res.full = 1'b0;
    found = '0;
    pair_sum = longint'(a) + longint'(b);
    case (op)
      OP_INSERT: begin
        key = pair_sum[KEY_W-1:0];
        slot = find_slot(key);
        if (slot < 0) begin
          res.full = 1'b1;
        end else begin
          slot_key[slot] = key;
          if (slot_count[slot] != COUNT_MAX) slot_count[slot] = slot_count[slot] + 1;
          res.count = slot_count[slot];
        end
      end
      OP_LOOKUP: begin
        negated = -pair_sum;
        if (negated < NEGATE_LIMIT) begin
          key = negated[KEY_W-1:0];
          slot = find_slot(key);
          if (slot >= 0) found = slot_count[slot];
          if (running_total > TOTAL_MAX - found) running_total = TOTAL_MAX;
          else running_total = running_total + found;
        end
        res.count = found;
      end
      OP_CLEAR: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) slot_count[i] = '0;
        running_total = '0;
      end
      default: ;
    endcase
    res.total = running_total;
    return res;
  endfunction

  function automatic longint signed_key(logic [KEY_W-1:0] k);
    logic signed [KEY_W-1:0] s;
    s = k;
    return longint'(s);
  endfunction

  function automatic longint random_value();
    logic signed [VALUE_W-1:0] v;
    v = VALUE_W'($urandom);
    return longint'(v);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] expected);
    if (mismatch_count < PRINT_LIMIT)
      $display("ERROR cycle %0d: %s got 0x%0h, expected 0x%0h", cycle_count, what, got,
               expected);
    mismatch_count++;
  endtask

  task automatic send_request(input op_t op, input longint a, input longint b);
    logic signed [VALUE_W-1:0] fa;
    logic signed [VALUE_W-1:0] fb;
    fa = a[VALUE_W-1:0];
    fb = b[VALUE_W-1:0];
    request_valid <= 1'b1;
    operation <= op;
    first_value <= fa;
    second_value <= fb;
    @(posedge clk);
    while (request_stall) @(posedge clk);
    outcome_q.push_back(hash_table_update(op, fa, fb));
    if (!quiet && $urandom_range(99) < 20) begin
      request_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  // The sum is split into two addends at a random point inside the value range.
  task automatic send_sum(input op_t op, input longint target);
    longint s;
    longint lo;
    longint hi;
    longint a;
    s = (target > 2 * VALUE_MAX) ? 2 * VALUE_MAX : target;
    lo = (s - VALUE_MAX > VALUE_MIN) ? s - VALUE_MAX : VALUE_MIN;
    hi = (s - VALUE_MIN < VALUE_MAX) ? s - VALUE_MIN : VALUE_MAX;
    a = lo + longint'($urandom_range(32'(hi - lo)));
    send_request(op, a, s - a);
  endtask

  task automatic settle();
    request_valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
  endtask

  task automatic build_key_pool();
    logic [SLOT_BITS-1:0] home;
    home = SLOT_BITS'($urandom);
    for (int i = 0; i < POOL_SIZE; i++) begin
      key_pool[i] = KEY_W'($urandom);
      if (i < 10) key_pool[i][SLOT_BITS-1:0] = home + SLOT_BITS'($urandom_range(2));
    end
    key_pool[POOL_SIZE-2] = '1;
    key_pool[POOL_SIZE-1] = KEY_NO_NEGATE;
  endtask

  task automatic send_mixed_request();
    int pick;
    pick = $urandom_range(99);
    if (pick < 45)
      send_sum(OP_INSERT, signed_key(key_pool[$urandom_range(POOL_SIZE-1)]));
    else if (pick < 80)
      send_sum(OP_LOOKUP, -signed_key(key_pool[$urandom_range(POOL_SIZE-1)]));
    else if (pick < 95)
      send_request(pick < 88 ? OP_INSERT : OP_LOOKUP, random_value(), random_value());
    else
      send_request(OP_NONE, random_value(), random_value());
  endtask

  task automatic test_directed_cases();
    send_request(OP_INSERT, VALUE_MAX, VALUE_MAX);
    send_request(OP_LOOKUP, -VALUE_MAX, -VALUE_MAX);
    send_request(OP_INSERT, VALUE_MIN, VALUE_MIN);
    send_request(OP_INSERT, VALUE_MIN, VALUE_MIN);
    send_request(OP_LOOKUP, VALUE_MIN, VALUE_MIN);
    send_request(OP_INSERT, 0, 0);
    send_request(OP_LOOKUP, 0, 0);
    send_request(OP_INSERT, -1, 0);
    send_request(OP_INSERT, -1 - SPAN, 0);
    send_request(OP_LOOKUP, 1 + SPAN, 0);
    send_request(OP_LOOKUP, 1, 0);
    send_request(OP_INSERT, 5, 0);
    send_request(OP_INSERT, 5 + SPAN, 0);
    send_request(OP_INSERT, 5 + 2 * SPAN, 0);
    send_request(OP_LOOKUP, -(5 + 2 * SPAN), 0);
    send_request(OP_LOOKUP, -(5 + 3 * SPAN), 0);
    send_request(OP_NONE, VALUE_MAX, VALUE_MIN);
    send_request(OP_INSERT, VALUE_MAX, VALUE_MIN);
    send_request(OP_CLEAR, VALUE_MIN, VALUE_MAX);
    send_request(OP_LOOKUP, 0, 0);
    send_request(OP_INSERT, 0, 0);
    settle();
  endtask

  task automatic test_output_backpressure();
    build_key_pool();
    quiet = 1'b1;
    hold_request = 1'b1;
    for (int i = 0; i < 40; i++) send_mixed_request();
    settle();
    quiet = 1'b0;
  endtask

  task automatic test_random_traffic(input int count);
    build_key_pool();
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) send_request(OP_CLEAR, random_value(), random_value());
      send_mixed_request();
    end
    settle();
  endtask

  task automatic test_steady_tail(input int count);
    quiet = 1'b1;
    for (int i = 0; i < count; i++) send_mixed_request();
    settle();
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && !quiet && $urandom_range(99) < 15) begin
        stall_left = $urandom_range(3, 1);
      end
      if (stall_left > 0) begin
        result_stall <= 1'b1;
        stall_left--;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (outcome_q.size() == 0) begin
        report_mismatch("result with no request pending, match_total", match_total, '0);
      end else begin
        want = outcome_q.pop_front();
        if (found_count !== want.count)
          report_mismatch("found_count", 64'(found_count), 64'(want.count));
        if (match_total !== want.total)
          report_mismatch("match_total", match_total, want.total);
        if (table_full !== want.full)
          report_mismatch("table_full", 64'(table_full), 64'(want.full));
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst <= 1'b1;
    request_valid <= 1'b0;
    operation <= OP_NONE;
    first_value <= '0;
    second_value <= '0;
    quiet = 1'b0;
    hold_request = 1'b0;
    mismatch_count = 0;
    running_total = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) slot_count[i] = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_output_backpressure();
    test_random_traffic(1250);
    test_steady_tail(120);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
